### rtl/opsd_pkg.sv
// ----------------------------------------------------------------------------
// opsd_pkg
// Types, constants and decode functions shared by the packet stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package opsd_pkg;

    localparam int unsigned KEY_SIZE   = 13;
    localparam int unsigned KEY_OFFSET = 7;

    typedef enum logic [1:0] {
        PH_LEN = 2'd0,
        PH_OPC = 2'd1,
        PH_CHK = 2'd2,
        PH_PAY = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic       is_payload;
        logic [7:0] payload_byte;
        logic [5:0] opcode;
        logic [7:0] payload_length;
        logic       packet_end;
        logic       check_ok;
        logic       truncated;
    } out_item_t;

    // one queued item: everything the back end needs to finish it
    typedef struct packed {
        logic       is_pay;
        logic [7:0] data;
        logic [3:0] kpos;
        logic       first;
        logic [5:0] opcode;
        logic [7:0] len;
        logic [7:0] base;
        logic [7:0] chk;
        logic       pend;
        logic       trunc;
    } qent_t;

    function automatic logic [2:0] perm3(input logic [2:0] i);
        logic [2:0] r;
        case (i)
            3'd0:    r = 3'd3;
            3'd1:    r = 3'd4;
            3'd2:    r = 3'd1;
            3'd3:    r = 3'd5;
            3'd4:    r = 3'd7;
            3'd5:    r = 3'd6;
            3'd6:    r = 3'd0;
            default: r = 3'd2;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] key_of(input logic [3:0] i);
        logic [7:0] r;
        case (i)
            4'd0:    r = 8'h3f;
            4'd1:    r = 8'h26;
            4'd2:    r = 8'h42;
            4'd3:    r = 8'hfd;
            4'd4:    r = 8'h8a;
            4'd5:    r = 8'h72;
            4'd6:    r = 8'h34;
            4'd7:    r = 8'h74;
            4'd8:    r = 8'hc8;
            4'd9:    r = 8'hbf;
            4'd10:   r = 8'hcd;
            4'd11:   r = 8'ha4;
            4'd12:   r = 8'h94;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // v mod 13 for v < 263: quotient by reciprocal 79/1024, exact in range
    function automatic logic [3:0] mod13(input logic [8:0] v);
        logic [15:0] p;
        logic [5:0]  q;
        logic [9:0]  qm;
        logic [8:0]  r;
        p  = 16'(v) * 16'd79;
        q  = p[15:10];
        qm = 10'(q) * 10'(KEY_SIZE);
        r  = v - qm[8:0];
        return r[3:0];
    endfunction

    function automatic logic [7:0] length_of(input logic [7:0] v);
        return {perm3(v[4:2]), v[1:0], perm3(v[7:5])};
    endfunction

    // v is the coded opcode already XORed with its key byte
    function automatic logic [5:0] opcode_of(input logic [7:0] v);
        logic [2:0] hi;
        hi = perm3(v[4:2]);
        return {hi[0], v[1:0], perm3(v[7:5])};
    endfunction

endpackage

`default_nettype wire

### rtl/opsd_chan_if.sv
// ----------------------------------------------------------------------------
// opsd_chan_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
`default_nettype none

interface opsd_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/opsd_front.sv
// ----------------------------------------------------------------------------
// opsd_front
// Header parser: tracks packet phase, decodes length and opcode, and queues
// one entry for each byte that produces a result.
// ----------------------------------------------------------------------------
`default_nettype none

module opsd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    opsd_chan_if.sink            stream,
    input  wire logic            q_full,
    output      logic            q_push,
    output      opsd_pkg::qent_t q_ent
);
    import opsd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] len_reg;
    logic [7:0] left_reg;
    logic [7:0] base_reg;
    logic [5:0] opc_reg;
    logic [7:0] chk_reg;
    logic [3:0] kpos_reg;
    logic       first_reg;

    logic       acc;
    logic [7:0] b;
    logic       eos;
    logic [7:0] len_dec;
    logic [7:0] base_dec;
    logic [5:0] opc_dec;
    logic [3:0] kpos_dec;
    logic       last_pay;

    assign stream.ready = !q_full;
    assign acc      = stream.valid && !q_full;
    assign b        = stream.data.stream_byte;
    assign eos      = stream.data.stream_end;
    assign len_dec  = length_of(b);
    assign base_dec = key_of(mod13({1'b0, len_reg})) ^ b;
    assign opc_dec  = opcode_of(base_dec);
    assign kpos_dec = mod13(9'(b) + 9'(KEY_OFFSET));
    assign last_pay = (left_reg == 8'd1);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (acc)
        begin
            unique case (phase_reg)
                PH_LEN: phase_next = eos ? PH_LEN : PH_OPC;
                PH_OPC: phase_next = eos ? PH_LEN : PH_CHK;
                PH_CHK: phase_next = (len_reg == 8'd0 || eos) ? PH_LEN : PH_PAY;
                PH_PAY: phase_next = (last_pay || eos) ? PH_LEN : PH_PAY;
                default: phase_next = PH_LEN;
            endcase
        end
    end

    // queue entry
    always_comb
    begin
        q_push        = 1'b0;
        q_ent         = '0;
        q_ent.data    = b;
        q_ent.kpos    = kpos_reg;
        q_ent.first   = first_reg;
        q_ent.opcode  = opc_reg;
        q_ent.len     = len_reg;
        q_ent.base    = base_reg;
        q_ent.chk     = chk_reg;
        unique case (phase_reg)
            PH_LEN:
            begin
                q_push       = acc && eos;
                q_ent.opcode = '0;
                q_ent.len    = len_dec;
                q_ent.pend   = 1'b1;
                q_ent.trunc  = 1'b1;
            end
            PH_OPC:
            begin
                q_push       = acc && eos;
                q_ent.opcode = opc_dec;
                q_ent.pend   = 1'b1;
                q_ent.trunc  = 1'b1;
            end
            PH_CHK:
            begin
                q_push      = acc && (eos || len_reg == 8'd0);
                q_ent.chk   = b;
                q_ent.pend  = 1'b1;
                q_ent.trunc = (len_reg != 8'd0);
            end
            PH_PAY:
            begin
                q_push       = acc;
                q_ent.is_pay = 1'b1;
                q_ent.pend   = last_pay || eos;
                q_ent.trunc  = !last_pay && eos;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    len_reg  <= len_dec;
                    left_reg <= len_dec;
                end
                PH_OPC:
                begin
                    base_reg <= base_dec;
                    opc_reg  <= opc_dec;
                    kpos_reg <= kpos_dec;
                end
                PH_CHK:
                begin
                    chk_reg   <= b;
                    first_reg <= 1'b1;
                end
                default:
                begin
                    left_reg  <= left_reg - 8'd1;
                    first_reg <= 1'b0;
                    kpos_reg  <= (kpos_reg == 4'(KEY_SIZE - 1)) ? 4'd0 : kpos_reg + 4'd1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/opsd_fifo.sv
// ----------------------------------------------------------------------------
// opsd_fifo
// Short queue between parser and payload decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module opsd_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire opsd_pkg::qent_t wdata,
    output      logic            full,
    output      logic            valid,
    input  wire logic            pop,
    output      opsd_pkg::qent_t rdata
);
    import opsd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qent_t         mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign valid   = (cnt_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign rdata   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

### rtl/opsd_back.sv
// ----------------------------------------------------------------------------
// opsd_back
// Payload decoder: unmasks payload bytes, keeps the alternating sum and
// evaluates the packet check into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module opsd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire opsd_pkg::qent_t q_ent,
    output      logic            q_pop,
    opsd_chan_if.source          result
);
    import opsd_pkg::*;

    logic       out_valid_reg;
    out_item_t  out_reg;
    logic [7:0] sum_reg;
    logic       odd_reg;

    logic       take;
    logic [7:0] d;
    logic [7:0] s_in;
    logic       odd_in;
    logic [7:0] s_new;
    out_item_t  out_next;

    assign take  = q_valid && (!out_valid_reg || result.ready);
    assign q_pop = take;

    assign d      = key_of(q_ent.kpos) ^ q_ent.data;
    assign s_in   = q_ent.first ? 8'd0 : sum_reg;
    assign odd_in = q_ent.first ? 1'b0 : odd_reg;

    always_comb
    begin
        // header results see a cleared sum
        if (!q_ent.is_pay)
        begin
            s_new = 8'd0;
        end
        else if (odd_in)
        begin
            s_new = s_in + d;
        end
        else
        begin
            s_new = s_in - d;
        end
        out_next.is_payload     = q_ent.is_pay;
        out_next.payload_byte   = q_ent.is_pay ? d : 8'd0;
        out_next.opcode         = q_ent.opcode;
        out_next.payload_length = q_ent.len;
        out_next.packet_end     = q_ent.pend;
        out_next.truncated      = q_ent.trunc;
        out_next.check_ok       = q_ent.pend && !q_ent.trunc
                                  && ((q_ent.chk ^ s_new ^ q_ent.base) == q_ent.len);
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            odd_reg       <= 1'b0;
            sum_reg       <= 8'd0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (take && q_ent.is_pay)
            begin
                sum_reg <= s_new;
                odd_reg <= !odd_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

### rtl/obfuscated_packet_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// obfuscated_packet_stream_decoder_core
// Decoder for an obfuscated byte stream of length/opcode/check headers and
// masked payloads.
// ----------------------------------------------------------------------------
// Usage:
//   stream: one encoded byte per item plus an end-of-stream mark.
//   result: one item per payload byte, and one per packet that closes on a
//           header byte (zero-length packet or stream end inside a header).
//           Header bytes that close nothing give no item.
//   Throughput is one byte per cycle while the queue is not full; a result
//   is queued by the parser, then the decoder loads the output register.
//   The parser stops taking bytes only when the queue is full, which happens
//   only when result.ready is held low; the output register then holds its
//   item until taken.
//   Reset clears phase, queue and output valid: the next byte is taken as a
//   length byte. Every byte marked stream_end also returns the parser to
//   the length phase.
// ----------------------------------------------------------------------------
`default_nettype none

module obfuscated_packet_stream_decoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    opsd_chan_if.sink   stream,
    opsd_chan_if.source result
);
    import opsd_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    qent_t q_wdata;
    qent_t q_rdata;

    opsd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .q_full (q_full),
        .q_push (q_push),
        .q_ent  (q_wdata)
    );

    opsd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .valid (q_valid),
        .pop   (q_pop),
        .rdata (q_rdata)
    );

    opsd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ent   (q_rdata),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

`default_nettype wire

### rtl/opsd_checker.sv
// ----------------------------------------------------------------------------
// opsd_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module opsd_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire opsd_pkg::out_item_t out_data
);
    import opsd_pkg::*;

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result item changed while stalled");

    a_check_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.check_ok |-> out_data.packet_end && !out_data.truncated)
        else $error("check_ok outside a complete packet end");

    a_trunc_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.truncated |-> out_data.packet_end)
        else $error("truncated item without packet_end");

    a_header_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.is_payload |->
            out_data.packet_end && out_data.payload_byte == 8'd0)
        else $error("header item not a clean packet end");

endmodule

bind obfuscated_packet_stream_decoder_core opsd_checker u_opsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);

`default_nettype wire
